/* rtl/bba_pkg.sv */
package bba_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 8192;
   localparam int BLOCK_W = 14;
   localparam int STATUS_W = 2;
   localparam int WORD_W = 32;
   localparam int WORD_SHIFT = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BLOCK_COUNT = 1'b0;
   localparam logic [BLOCK_W-1:0] BLOCK_COUNT_RESET = 14'd8192;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

   typedef struct packed {
      logic action;
      logic [BLOCK_W-1:0] block_number;
   } req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] result_block;
      logic [STATUS_W-1:0] status;
      logic [BLOCK_W-1:0] free_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic rd;
      logic step;
      logic commit_alloc;
      logic commit_free;
      logic set_status;
      logic [STATUS_W-1:0] status;
      logic reply;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_free;
      logic range_bad;
      logic past_limit;
      logic found;
      logic word_full;
      logic bit_set;
      logic out_busy;
   } stat_type;

endpackage

/* rtl/bba_ram.sv */
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic clock,
   input  logic en,
   input  logic we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/bba_ctrl.sv */
module bba_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  bba_pkg::stat_type st,
   output bba_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_EVAL  = 4'b0100,
      S_REPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (st.is_free) begin
               if (st.range_bad) begin
                  cmd.set_status = 1'b1;
                  cmd.status = bba_pkg::ST_RANGE;
                  state_in = S_REPLY;
               end else begin
                  cmd.rd = 1'b1;
                  state_in = S_EVAL;
               end
            end else begin
               if (st.past_limit) begin
                  cmd.set_status = 1'b1;
                  cmd.status = bba_pkg::ST_FULL;
                  state_in = S_REPLY;
               end else begin
                  cmd.rd = 1'b1;
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            if (st.is_free) begin
               cmd.set_status = 1'b1;
               if (st.bit_set) begin
                  cmd.commit_free = 1'b1;
                  cmd.status = bba_pkg::ST_OK;
               end else begin
                  cmd.status = bba_pkg::ST_ALREADY_FREE;
               end
               state_in = S_REPLY;
            end else if (st.found) begin
               cmd.commit_alloc = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status = bba_pkg::ST_OK;
               state_in = S_REPLY;
            end else if (st.word_full) begin
               // whole word taken, try the next one
               cmd.step = 1'b1;
               state_in = S_ISSUE;
            end else begin
               // only bits past the limit are clear
               cmd.set_status = 1'b1;
               cmd.status = bba_pkg::ST_FULL;
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (!st.out_busy) begin
               cmd.reply = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/bba_dpath.sv */
module bba_dpath #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic [bba_pkg::BLOCK_W-1:0] block_count,
   input  bba_pkg::req_type req_data,
   input  bba_pkg::cmd_type cmd,
   output bba_pkg::stat_type st,
   input  logic rsp_stall,
   output logic rsp_valid,
   output bba_pkg::rsp_type rsp_data
);

   localparam int WW = bba_pkg::WORD_W;
   localparam int WS = bba_pkg::WORD_SHIFT;
   localparam int BW = bba_pkg::BLOCK_W;
   localparam int WORDS = (MAX_BLOCKS + WW - 1) / WW;
   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int XW = AW + BW;
   localparam int CW = (AW + WS + 1 > BW + 1) ? AW + WS + 1 : BW + 1;

   logic act_ff, act_in;
   logic [BW-1:0] num_ff, num_in;
   logic [BW-1:0] lim_ff, lim_in;
   logic [AW:0] word_ff, word_in;
   logic [AW:0] hint_ff, hint_in;   // every word below is all ones
   logic [AW:0] hw_ff, hw_in;       // words at and above were never written
   logic [BW-1:0] used_ff, used_in;
   logic rd_zero_ff, rd_zero_in;
   logic [bba_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [BW-1:0] result_ff, result_in;
   logic rsp_valid_ff, rsp_valid_in;
   bba_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [BW-1:0] idx;
   logic [XW-1:0] idx_x;
   logic [AW-1:0] fword;
   logic [WS-1:0] fbit;
   logic [AW+WS:0] base;
   logic [CW-1:0] base_c, lim_c, rem;
   logic [WW-1:0] ram_rdata, data, lim_mask, avail, wdata_alloc, wdata_free, ram_wdata;
   logic [AW-1:0] ram_addr;
   logic found;
   logic [WS-1:0] pos;
   logic [BW-1:0] free_cnt;
   logic ram_en, ram_we;

   assign idx = num_ff - BW'(1);
   assign idx_x = XW'(idx);
   assign fword = idx_x[AW+WS-1:WS];
   assign fbit = idx[WS-1:0];

   assign base = {word_ff, {WS{1'b0}}};
   assign base_c = CW'(base);
   assign lim_c = CW'(lim_ff);
   assign rem = lim_c - base_c;

   assign data = rd_zero_ff ? '0 : ram_rdata;
   assign lim_mask = (rem >= CW'(WW)) ? '1 : ((WW'(1) << rem[WS-1:0]) - WW'(1));
   assign avail = ~data & lim_mask;

   always_comb begin
      found = 1'b0;
      pos = '0;
      for (int b = WW - 1; b >= 0; b--) begin
         if (avail[b]) begin
            found = 1'b1;
            pos = WS'(b);
         end
      end
   end

   assign wdata_alloc = data | (WW'(1) << pos);
   assign wdata_free = data & ~(WW'(1) << fbit);

   assign ram_addr = (act_ff == bba_pkg::ACT_FREE) ? fword : word_ff[AW-1:0];
   assign ram_we = cmd.commit_alloc | cmd.commit_free;
   assign ram_en = cmd.rd | ram_we;
   assign ram_wdata = (act_ff == bba_pkg::ACT_FREE) ? wdata_free : wdata_alloc;

   bba_ram #(
      .WIDTH(WW),
      .DEPTH(WORDS)
   ) u_map (
      .clock(clock),
      .en(ram_en),
      .we(ram_we),
      .addr(ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign free_cnt = (lim_ff > used_ff) ? (lim_ff - used_ff) : '0;

   assign st.is_free = (act_ff == bba_pkg::ACT_FREE);
   assign st.range_bad = (num_ff == '0) || (num_ff > lim_ff);
   assign st.past_limit = (base_c >= lim_c);
   assign st.found = found;
   assign st.word_full = &data;
   assign st.bit_set = data[fbit];
   assign st.out_busy = rsp_valid_ff & rsp_stall;

   always_comb begin
      act_in = act_ff;
      num_in = num_ff;
      lim_in = lim_ff;
      word_in = word_ff;
      hint_in = hint_ff;
      hw_in = hw_ff;
      used_in = used_ff;
      rd_zero_in = rd_zero_ff;
      status_in = status_ff;
      result_in = result_ff;

      if (cmd.accept) begin
         act_in = req_data.action;
         num_in = req_data.block_number;
         if (32'(block_count) > 32'(MAX_BLOCKS)) begin
            lim_in = BW'(MAX_BLOCKS);
         end else begin
            lim_in = block_count;
         end
         word_in = hint_ff;
         result_in = '0;
      end
      if (cmd.rd) begin
         if (act_ff == bba_pkg::ACT_FREE) begin
            rd_zero_in = ({1'b0, fword} >= hw_ff);
         end else begin
            rd_zero_in = (word_ff >= hw_ff);
         end
      end
      if (cmd.step) begin
         word_in = word_ff + (AW+1)'(1);
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
      if (cmd.commit_alloc) begin
         result_in = BW'(base_c + CW'(pos) + CW'(1));
         used_in = used_ff + BW'(1);
         if (word_ff == hw_ff) begin
            hw_in = hw_ff + (AW+1)'(1);
         end
         hint_in = (&wdata_alloc) ? word_ff + (AW+1)'(1) : word_ff;
      end
      if (cmd.commit_free) begin
         if (used_ff != '0) begin
            used_in = used_ff - BW'(1);
         end
         if ({1'b0, fword} < hint_ff) begin
            hint_in = {1'b0, fword};
         end
      end
   end

   assign rsp_valid_in = cmd.reply | (rsp_valid_ff & rsp_stall);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.reply) begin
         rsp_data_in.result_block = result_ff;
         rsp_data_in.status = status_ff;
         rsp_data_in.free_count = free_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hint_ff <= '0;
         hw_ff <= '0;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hint_ff <= hint_in;
         hw_ff <= hw_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      num_ff <= num_in;
      lim_ff <= lim_in;
      word_ff <= word_in;
      rd_zero_ff <= rd_zero_in;
      status_ff <= status_in;
      result_ff <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   hint_below_hw: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= hw_ff)
      else $error("allocation hint beyond written words");

   used_fits_written: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(used_ff) <= (CW + 1)'({hw_ff, {WS{1'b0}}}))
      else $error("used count exceeds bits ever written");

   free_drops_used: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_free |=> used_ff == $past(used_ff) - BW'(1))
      else $error("free of a used block did not lower the count");

   no_reply_over_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.reply |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a stalled beat");

endmodule

/* rtl/bitmap_block_allocator.sv */
// Flow: ISSUE starts a bitmap RAM read, EVAL checks the word, REPLY loads the result beat;
// a free out of range, or a scan reaching a word that starts past the limit, skips the read
// and EVAL. Each word passed over repeats ISSUE and EVAL (bitmap RAM read+check), and REPLY
// waits while the last beat is stalled. Requests are taken one at a time, out of IDLE only.
// Reset: block_count returns to 8192, counts and hint clear; the bitmap RAM is not swept,
// a written-word mark makes every word never written read as all free, so no clearing pass.
module bitmap_block_allocator #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  bba_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output bba_pkg::rsp_type rsp_data,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);

   logic [bba_pkg::BLOCK_W-1:0] block_count_ff, block_count_in;
   bba_pkg::cmd_type cmd;
   bba_pkg::stat_type st;

   always_comb begin
      block_count_in = block_count_ff;
      if (psel && penable && pwrite && (paddr[2] == bba_pkg::REG_BLOCK_COUNT)) begin
         block_count_in = pwdata[bba_pkg::BLOCK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= bba_pkg::BLOCK_COUNT_RESET;
      end else begin
         block_count_ff <= block_count_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == bba_pkg::REG_BLOCK_COUNT) ?
                   bba_pkg::CSR_DATA_W'(block_count_ff) : '0;

   bba_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .st(st),
      .cmd(cmd)
   );

   bba_dpath #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .block_count(block_count_ff),
      .req_data(req_data),
      .cmd(cmd),
      .st(st),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

endmodule
